FILE: hdl/potential_field_steering_macros.svh
// Assertion helpers for the potential field steering block.
`ifndef POTENTIAL_FIELD_STEERING_MACROS_SVH
`define POTENTIAL_FIELD_STEERING_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define PFS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds through reset.
`define PFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/pfs_pkg.sv
package pfs_pkg;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROT, ST_TPREP, ST_DIV, ST_TACC, ST_NET0, ST_MULX, ST_MULY,
    ST_HEAD, ST_VEC, ST_HFIN, ST_MULV, ST_MULR, ST_STP, ST_STD, ST_STF
  } state_e;

  typedef enum logic [2:0] {
    REG_SCALE_X, REG_SCALE_Y, REG_OFFSET_X, REG_OFFSET_Y,
    REG_SPEED_GAIN, REG_STEER_P, REG_STEER_D
  } reg_idx_e;

  localparam int CW     = 60;  // CORDIC x/y width
  localparam int ZW     = 20;  // CORDIC angle width, Q.16
  localparam int SUM_W  = 48;
  localparam int TERM_W = 22;
  localparam int DVD_W  = 29;  // divider dividend / quotient
  localparam int DVS_W  = 32;  // divider divisor
  localparam int MUL_W  = 72;
  localparam int MPL_W  = 23;

  localparam logic signed [CW-1:0]    CORDIC_K    = 60'sd652032875;
  localparam logic signed [15:0]      ANGLE_LIMIT = 16'sd12867;
  localparam logic [TERM_W-1:0]       TERM_CAP    = 22'd1048576;
  localparam logic signed [ZW-1:0]    HALF_RAD    = 20'sd32768;
  localparam logic signed [MUL_W-1:0] SPEED_MAX   = 72'sd50331648;
  localparam logic signed [MUL_W-1:0] NX_MAX      = 72'sd1099511627776;
  localparam logic [MPL_W-1:0]        RPM_CONST   = 23'd4927738;
  localparam logic [16:0]             TERM_MULT   = 17'd125000;
  localparam logic signed [47:0]      STEER_MID   = 48'sd17179869184;

  function automatic logic [15:0] atan_q16(input logic [3:0] i);
    logic [15:0] v;
    case (i)
      4'd0:    v = 16'd51472;
      4'd1:    v = 16'd30386;
      4'd2:    v = 16'd16055;
      4'd3:    v = 16'd8150;
      4'd4:    v = 16'd4091;
      4'd5:    v = 16'd2047;
      4'd6:    v = 16'd1024;
      4'd7:    v = 16'd512;
      4'd8:    v = 16'd256;
      4'd9:    v = 16'd128;
      4'd10:   v = 16'd64;
      4'd11:   v = 16'd32;
      4'd12:   v = 16'd16;
      4'd13:   v = 16'd8;
      4'd14:   v = 16'd4;
      default: v = 16'd2;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/potential_field_steering.sv
// Potential field steering controller.
// Input channel: one lidar item per handshake (range_mm_i, sample_angle_i,
// last_sample_i), taken when in_valid_i is high and in_stall_o is low.
// Output channel: one command item (motor_rpm_o, steer_command_o) per scan,
// held in an output register until out_stall_i is low with out_valid_o high.
// Config: cfg_we_i writes cfg_wdata_i into register cfg_idx_i (0..6) at once;
// write only while the block is idle.
// One item is worked on at a time; in_stall_o is high while busy.
// Kept sample: CORDIC rotation, then two terms, each of set-up, the
// bit-serial divider and accumulate; the next item is taken only after the
// second term. An ignored sample is dropped and the block stays idle.
// Last sample: four passes of the shared shift-add multiplier, a vectoring
// CORDIC for the heading and six other steps follow; the vectoring CORDIC
// is skipped when the net forward force is not positive. A kept last item
// first goes through its terms, an ignored one goes straight to these steps.
// The result sits in the output register; if the receiver stalls, the next
// items are still taken, and a new result waits only at the final step.
// Reset: sums and previous heading cleared, registers to defaults, no item
// pending.

`include "potential_field_steering_macros.svh"

module potential_field_steering (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [15:0]       range_mm_i,
  input  logic signed [15:0] sample_angle_i,
  input  logic              last_sample_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [8:0] motor_rpm_o,
  output logic [7:0]        steer_command_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i
);

  localparam int CW = pfs_pkg::CW;
  localparam int ZW = pfs_pkg::ZW;
  localparam int SW = pfs_pkg::SUM_W;
  localparam int MW = pfs_pkg::MUL_W;

  pfs_pkg::state_e state_q, state_d;

  // configuration registers
  logic [15:0]        scale_x_q, scale_y_q, gain_q;
  logic signed [15:0] off_x_q, off_y_q, p_gain_q, d_gain_q;

  // item latches
  logic [15:0] r_q;
  logic [31:0] rsq_q;
  logic        last_q, sel_q;

  // shared CORDIC
  logic signed [CW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic [3:0]           it_q;
  logic                 rot_q;

  // state kept across items
  logic signed [SW-1:0] sum_x_q, sum_y_q;
  logic signed [15:0]   prev_q, h_q;

  // shared shift-add multiplier
  logic signed [MW-1:0]      mcand_q, acc_q, acc_nxt;
  logic [pfs_pkg::MPL_W-1:0] mpl_q;
  logic [4:0]                mcnt_q;
  logic                      mul_last;

  logic signed [CW-1:0] net_x_q, net_y_q;
  logic [7:0]           rpm_q;
  logic signed [31:0]   stp_q;
  logic signed [32:0]   std_q;

  logic out_valid_q;
  logic [8:0] rpm_out_q;
  logic [7:0] cmd_q;

  logic gate, out_busy, div_start, div_done;
  logic [pfs_pkg::DVD_W-1:0] div_q, div_n;

  assign gate = (sample_angle_i >= -pfs_pkg::ANGLE_LIMIT) &&
                (sample_angle_i <= pfs_pkg::ANGLE_LIMIT) && (range_mm_i != 16'hFFFF);
  assign out_busy = out_valid_q && out_stall_i;
  assign mul_last = mcnt_q == 5'(pfs_pkg::MPL_W - 1);
  assign acc_nxt  = acc_q + (mpl_q[0] ? mcand_q : '0);

  // ---- CORDIC micro-rotation ----
  logic signed [CW-1:0] dx, dy;
  logic signed [ZW-1:0] at;
  logic                 dir;
  assign dx  = y_q >>> it_q;
  assign dy  = x_q >>> it_q;
  assign at  = ZW'(pfs_pkg::atan_q16(it_q));
  assign dir = rot_q ? !z_q[ZW-1] : y_q[CW-1];

  // ---- repulsive term ----
  logic signed [CW-1:0] cval, cabs;
  logic [48:0]          nprod;
  logic [pfs_pkg::TERM_W-1:0] mag;
  logic signed [pfs_pkg::TERM_W-1:0] term;
  logic signed [SW:0]   acc_sum;
  logic signed [SW-1:0] sat_sum;
  assign cval  = sel_q ? y_q : x_q;
  assign cabs  = cval[CW-1] ? -cval : cval;
  assign nprod = cabs[31:0] * pfs_pkg::TERM_MULT;
  assign div_n = nprod[47:19];

  always_comb begin
    if (cval == '0) begin
      mag = '0;
    end else if (r_q == '0 || div_q > pfs_pkg::DVD_W'(pfs_pkg::TERM_CAP)) begin
      mag = pfs_pkg::TERM_CAP;
    end else begin
      mag = pfs_pkg::TERM_W'(div_q);
    end
    term    = cval[CW-1] ? $signed(mag) : -$signed(mag);
    acc_sum = (sel_q ? {sum_y_q[SW-1], sum_y_q} : {sum_x_q[SW-1], sum_x_q})
              + (SW+1)'(term);
    if (acc_sum[SW] != acc_sum[SW-1]) begin
      sat_sum = acc_sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sat_sum = acc_sum[SW-1:0];
    end
  end

  // ---- net force, heading, steering ----
  logic signed [MW-1:0] prod_sh;
  logic signed [CW-1:0] net_new;
  logic signed [15:0]   off_sel;
  logic signed [ZW-1:0] zc, zr;
  logic signed [33:0]   st;
  logic signed [47:0]   st48, t48;
  logic signed [20:0]   cmd21;
  logic [7:0]           cmd_new;
  logic signed [16:0]   dh;

  assign prod_sh = acc_nxt >>> 8;
  assign off_sel = (state_q == pfs_pkg::ST_MULX) ? off_x_q : off_y_q;
  assign net_new = prod_sh[CW-1:0] + {{(CW-24){off_sel[15]}}, off_sel, 8'b0};
  assign zc = (z_q > pfs_pkg::HALF_RAD) ? pfs_pkg::HALF_RAD :
              (z_q < -pfs_pkg::HALF_RAD) ? -pfs_pkg::HALF_RAD : z_q;
  assign zr = (zc + ZW'(4)) >>> 3;
  assign dh = {h_q[15], h_q} - {prev_q[15], prev_q};
  assign st = {{2{stp_q[31]}}, stp_q} + {std_q[32], std_q};
  assign st48 = {{14{st[33]}}, st};
  assign t48  = pfs_pkg::STEER_MID - (st48 <<< 9) + (st48 <<< 1);
  assign cmd21 = t48[47:27];
  assign cmd_new = (cmd21 > 21'sd240) ? 8'd240 :
                   (cmd21 < 21'sd10) ? 8'd10 : cmd21[7:0];

  // ---- divider ----
  pfs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (rsq_q),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  // ---- sequencer: next state ----
  always_comb begin
    state_d = state_q;
    case (state_q)
      pfs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (gate) begin
            state_d = pfs_pkg::ST_ROT;
          end else if (last_sample_i) begin
            state_d = pfs_pkg::ST_NET0;
          end
        end
      end
      pfs_pkg::ST_ROT:   if (it_q == 4'd15) state_d = pfs_pkg::ST_TPREP;
      pfs_pkg::ST_TPREP: state_d = pfs_pkg::ST_DIV;
      pfs_pkg::ST_DIV:   if (div_done) state_d = pfs_pkg::ST_TACC;
      pfs_pkg::ST_TACC: begin
        if (!sel_q) begin
          state_d = pfs_pkg::ST_TPREP;
        end else begin
          state_d = last_q ? pfs_pkg::ST_NET0 : pfs_pkg::ST_IDLE;
        end
      end
      pfs_pkg::ST_NET0:  state_d = pfs_pkg::ST_MULX;
      pfs_pkg::ST_MULX:  if (mul_last) state_d = pfs_pkg::ST_MULY;
      pfs_pkg::ST_MULY:  if (mul_last) state_d = pfs_pkg::ST_HEAD;
      pfs_pkg::ST_HEAD: begin
        state_d = (net_x_q[CW-1] || net_x_q == '0) ? pfs_pkg::ST_HFIN : pfs_pkg::ST_VEC;
      end
      pfs_pkg::ST_VEC:   if (it_q == 4'd15) state_d = pfs_pkg::ST_HFIN;
      pfs_pkg::ST_HFIN:  state_d = pfs_pkg::ST_MULV;
      pfs_pkg::ST_MULV:  if (mul_last) state_d = pfs_pkg::ST_MULR;
      pfs_pkg::ST_MULR:  if (mul_last) state_d = pfs_pkg::ST_STP;
      pfs_pkg::ST_STP:   state_d = pfs_pkg::ST_STD;
      pfs_pkg::ST_STD:   state_d = pfs_pkg::ST_STF;
      pfs_pkg::ST_STF:   if (!out_busy) state_d = pfs_pkg::ST_IDLE;
      default:           state_d = pfs_pkg::ST_IDLE;
    endcase
  end

  // ---- sequencer: outputs ----
  always_comb begin
    in_stall_o = state_q != pfs_pkg::ST_IDLE;
    div_start  = state_q == pfs_pkg::ST_TPREP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---- configuration ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q <= 16'd5248;
      scale_y_q <= 16'd2560;
      off_x_q   <= 16'sd1000;
      off_y_q   <= 16'sd500;
      gain_q    <= 16'd3277;
      p_gain_q  <= 16'sd9830;
      d_gain_q  <= 16'sd1638;
    end else if (cfg_we_i) begin
      case (pfs_pkg::reg_idx_e'(cfg_idx_i))
        pfs_pkg::REG_SCALE_X:    scale_x_q <= cfg_wdata_i;
        pfs_pkg::REG_SCALE_Y:    scale_y_q <= cfg_wdata_i;
        pfs_pkg::REG_OFFSET_X:   off_x_q   <= cfg_wdata_i;
        pfs_pkg::REG_OFFSET_Y:   off_y_q   <= cfg_wdata_i;
        pfs_pkg::REG_SPEED_GAIN: gain_q    <= cfg_wdata_i;
        pfs_pkg::REG_STEER_P:    p_gain_q  <= cfg_wdata_i;
        pfs_pkg::REG_STEER_D:    d_gain_q  <= cfg_wdata_i;
        default: ;  // unknown index ignored
      endcase
    end
  end

  // ---- control state: sums, heading, output register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == pfs_pkg::ST_TACC) begin
        if (sel_q) sum_y_q <= sat_sum;
        else       sum_x_q <= sat_sum;
      end
      if (state_q == pfs_pkg::ST_STF && !out_busy) begin
        out_valid_q <= 1'b1;
        prev_q      <= h_q;
        sum_x_q     <= '0;
        sum_y_q     <= '0;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---- datapath ----
  always_ff @(posedge clk_i) begin
    case (state_q)
      pfs_pkg::ST_IDLE: begin
        r_q    <= range_mm_i;
        rsq_q  <= range_mm_i * range_mm_i;
        last_q <= last_sample_i;
        x_q    <= pfs_pkg::CORDIC_K;
        y_q    <= '0;
        z_q    <= ZW'($signed({sample_angle_i, 3'b000}));
        it_q   <= '0;
        rot_q  <= 1'b1;
        sel_q  <= 1'b0;
      end
      pfs_pkg::ST_ROT, pfs_pkg::ST_VEC: begin
        if (dir) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + at;
        end
        it_q <= it_q + 4'd1;
      end
      pfs_pkg::ST_TACC: sel_q <= 1'b1;
      pfs_pkg::ST_NET0: begin
        mcand_q <= MW'(sum_x_q);
        mpl_q   <= pfs_pkg::MPL_W'(scale_x_q);
        acc_q   <= '0;
        mcnt_q  <= '0;
      end
      pfs_pkg::ST_MULX, pfs_pkg::ST_MULY, pfs_pkg::ST_MULV, pfs_pkg::ST_MULR: begin
        if (!mul_last) begin
          acc_q   <= acc_nxt;
          mcand_q <= mcand_q <<< 1;
          mpl_q   <= mpl_q >> 1;
          mcnt_q  <= mcnt_q + 5'd1;
        end else begin
          acc_q  <= '0;
          mcnt_q <= '0;
          case (state_q)
            pfs_pkg::ST_MULX: begin
              net_x_q <= net_new;
              mcand_q <= MW'(sum_y_q);
              mpl_q   <= pfs_pkg::MPL_W'(scale_y_q);
            end
            pfs_pkg::ST_MULY: net_y_q <= net_new;
            pfs_pkg::ST_MULV: begin
              mcand_q <= (acc_nxt > pfs_pkg::SPEED_MAX) ? pfs_pkg::SPEED_MAX : acc_nxt;
              mpl_q   <= pfs_pkg::RPM_CONST;
            end
            default: rpm_q <= acc_nxt[47:40];
          endcase
        end
      end
      pfs_pkg::ST_HEAD: begin
        x_q   <= net_x_q;
        y_q   <= net_y_q;
        it_q  <= '0;
        rot_q <= 1'b0;
        if (!(net_x_q[CW-1] || net_x_q == '0)) begin
          z_q <= '0;
        end else if (net_x_q == '0 && net_y_q == '0) begin
          z_q <= '0;
        end else begin
          z_q <= net_y_q[CW-1] ? -pfs_pkg::HALF_RAD : pfs_pkg::HALF_RAD;
        end
      end
      pfs_pkg::ST_HFIN: begin
        h_q <= zr[15:0];
        if (net_x_q[CW-1]) begin
          mcand_q <= '0;
        end else begin
          mcand_q <= (MW'(net_x_q) > pfs_pkg::NX_MAX) ? pfs_pkg::NX_MAX : MW'(net_x_q);
        end
        mpl_q  <= pfs_pkg::MPL_W'(gain_q);
        acc_q  <= '0;
        mcnt_q <= '0;
      end
      pfs_pkg::ST_STP: stp_q <= p_gain_q * h_q;
      pfs_pkg::ST_STD: std_q <= d_gain_q * dh;
      pfs_pkg::ST_STF: begin
        if (!out_busy) begin
          rpm_out_q <= 9'd0 - {1'b0, rpm_q};
          cmd_q     <= cmd_new;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign motor_rpm_o     = rpm_out_q;
  assign steer_command_o = cmd_q;

  // ---- checks ----
  `PFS_ASSERT(a_sums_clear, clk_i, rst_ni, $rose(out_valid_o) |-> (sum_x_q == '0 && sum_y_q == '0), "force sums not cleared with result")
  `PFS_ASSERT(a_steer_range, clk_i, rst_ni, out_valid_o |-> (steer_command_o >= 8'd10 && steer_command_o <= 8'd240), "steer command out of range")
  `PFS_ASSERT(a_rpm_sign, clk_i, rst_ni, out_valid_o |-> (motor_rpm_o <= 9'sd0), "motor rpm positive")

endmodule

FILE: hdl/pfs_div.sv
module pfs_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pfs_pkg::DVD_W-1:0] dividend_i,
  input  logic [pfs_pkg::DVS_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [pfs_pkg::DVD_W-1:0] quot_o
);

  logic [pfs_pkg::DVS_W-1:0] rem_q;
  logic [pfs_pkg::DVS_W-1:0] dvs_q;
  logic [pfs_pkg::DVD_W-1:0] quo_q;
  logic [4:0]                cnt_q;
  logic                      busy_q, done_q;
  logic [pfs_pkg::DVS_W:0]   trial;
  logic                      fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[pfs_pkg::DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(pfs_pkg::DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? pfs_pkg::DVS_W'(trial - {1'b0, dvs_q}) : trial[pfs_pkg::DVS_W-1:0];
      quo_q <= {quo_q[pfs_pkg::DVD_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
